[rtl/bridge_mac_table_with_aging_defines.svh]
// assertion macros for the bridge address table
// included by the top level only, no other dependencies
`ifndef BRIDGE_MAC_TABLE_WITH_AGING_DEFINES_SVH
`define BRIDGE_MAC_TABLE_WITH_AGING_DEFINES_SVH

`ifndef ASSERT_OFF
// check under reset gating
`define BMT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bmt assertion failed");
// check at every edge, reset included
`define BMT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bmt assertion failed");
`else
`define BMT_ASSERT(lbl, clk, rstn, prop)
`define BMT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/bmt_pkg.sv]
// shared types and constants of the bridge address table
// no dependencies
`default_nettype none

package bmt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int LIFE_WIDTH_DEF  = 16;
    localparam int NUM_PORTS       = 8;

    localparam int ADDR_W   = 48;
    localparam int PORT_W   = 3;
    localparam int ACTION_W = 3;
    localparam int MASK_W   = 8;
    localparam int TOUT_W   = 16;
    localparam int ACTP_W   = 4;

    localparam logic [TOUT_W-1:0] TIMEOUT_RESET = 16'd300;
    localparam logic [ACTP_W-1:0] ACTIVE_RESET  = 4'd8;

    // register indexes on the configuration port
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_ACTIVE  = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_DROP    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_UNICAST = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FLOOD   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_LEARNED = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FULL    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd5;

    typedef struct packed {
        logic clr_wr;
        logic cnt_clear;
        logic load_in;
        logic scan_rd;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

[rtl/bmt_ram.sv]
// generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module bmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/bmt_dp.sv]
// datapath of the bridge address table: item latch, table ram, scan and result
// depends on bmt_pkg and bmt_ram
`default_nettype none

module bmt_dp #(
    parameter int TABLE_DEPTH = bmt_pkg::TABLE_DEPTH_DEF,
    parameter int LIFE_WIDTH  = bmt_pkg::LIFE_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bmt_pkg::ctrl_cmd_t             cmd,
    output bmt_pkg::ctrl_status_t               status,
    input  wire logic                           req_type,
    input  wire logic [bmt_pkg::ADDR_W-1:0]     dest_addr,
    input  wire logic [bmt_pkg::ADDR_W-1:0]     src_addr,
    input  wire logic [bmt_pkg::PORT_W-1:0]     arrival_port,
    input  wire logic                           is_register,
    input  wire logic [bmt_pkg::ADDR_W-1:0]     registered_addr,
    input  wire logic [bmt_pkg::TOUT_W-1:0]     entry_timeout,
    input  wire logic [bmt_pkg::ACTP_W-1:0]     active_ports,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic      [bmt_pkg::ACTION_W-1:0]   action,
    output logic      [bmt_pkg::MASK_W-1:0]     out_port_mask
);

    localparam int IW        = $clog2(TABLE_DEPTH);
    localparam int LW        = LIFE_WIDTH;
    localparam int PORT_LO   = LW;
    localparam int ADDR_LO   = LW + bmt_pkg::PORT_W;
    localparam int VALID_BIT = ADDR_LO + bmt_pkg::ADDR_W;
    localparam int EW        = VALID_BIT + 1;
    localparam logic [31:0] LIFE_MAX = 32'((64'd1 << LW) - 64'd1);

    // counter shared by the clearing pass and the scans
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          pend_reg;
    logic [IW-1:0] pend_idx_reg;

    // latched item
    logic                          tick_reg;
    logic [bmt_pkg::ADDR_W-1:0]    dest_reg, src_reg, raddr_reg;
    logic [bmt_pkg::PORT_W-1:0]    port_reg;
    logic                          isreg_reg;

    // scan results
    logic                       dst_hit_reg, dst_hit_next;
    logic [bmt_pkg::PORT_W-1:0] dst_port_reg, dst_port_next;
    logic                       src_hit_reg, src_hit_next;
    logic [bmt_pkg::PORT_W-1:0] src_port_reg, src_port_next;
    logic                       ra_hit_reg, ra_hit_next;
    logic [IW-1:0]              ra_idx_reg, ra_idx_next;
    logic                       free_hit_reg, free_hit_next;
    logic [IW-1:0]              free_idx_reg, free_idx_next;

    logic                              out_valid_reg, out_valid_next;
    logic [bmt_pkg::ACTION_W-1:0]      action_reg, action_next;
    logic [bmt_pkg::MASK_W-1:0]        mask_reg, mask_next;

    logic          we;
    logic [IW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [EW-1:0] rdata;

    logic                       ent_valid;
    logic [bmt_pkg::ADDR_W-1:0] ent_addr;
    logic [bmt_pkg::PORT_W-1:0] ent_port;
    logic [LW-1:0]              ent_life;
    logic [LW-1:0]              start_life;
    logic [31:0]                tout32;
    logic                       learn_go;
    logic [bmt_pkg::ACTP_W-1:0] flood_n;
    logic [bmt_pkg::MASK_W-1:0] flood_mask;

    bmt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.scan_rd),
        .raddr (cnt_reg),
        .rdata (rdata)
    );

    assign ent_valid = rdata[VALID_BIT];
    assign ent_addr  = rdata[VALID_BIT-1:ADDR_LO];
    assign ent_port  = rdata[ADDR_LO-1:PORT_LO];
    assign ent_life  = rdata[LW-1:0];

    // zero timeout means one tick, too wide saturates
    always_comb
    begin
        tout32 = {16'd0, entry_timeout};
        if (entry_timeout == '0)
        begin
            tout32 = 32'd1;
        end
        if (tout32 > LIFE_MAX)
        begin
            start_life = LIFE_MAX[LW-1:0];
        end
        else
        begin
            start_life = tout32[LW-1:0];
        end
    end

    assign learn_go = cmd.finish && !tick_reg && !dst_hit_reg && !src_hit_reg && isreg_reg
                      && (ra_hit_reg || free_hit_reg);

    // write port: clearing pass, aging write-back, learn
    always_comb
    begin
        we    = 1'b0;
        waddr = cnt_reg;
        wdata = '0;
        if (cmd.clr_wr)
        begin
            we = 1'b1;
        end
        else if (pend_reg && tick_reg && ent_valid)
        begin
            we    = 1'b1;
            waddr = pend_idx_reg;
            if (ent_life <= LW'(1))
            begin
                wdata = {1'b0, ent_addr, ent_port, {LW{1'b0}}};
            end
            else
            begin
                wdata = {1'b1, ent_addr, ent_port, ent_life - LW'(1)};
            end
        end
        else if (learn_go)
        begin
            we    = 1'b1;
            waddr = ra_hit_reg ? ra_idx_reg : free_idx_reg;
            wdata = {1'b1, raddr_reg, port_reg, start_life};
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.clr_wr || cmd.scan_rd)
        begin
            cnt_next = cnt_reg + IW'(1);
        end
    end

    // first match wins, lowest index first
    always_comb
    begin
        dst_hit_next  = dst_hit_reg;
        dst_port_next = dst_port_reg;
        src_hit_next  = src_hit_reg;
        src_port_next = src_port_reg;
        ra_hit_next   = ra_hit_reg;
        ra_idx_next   = ra_idx_reg;
        free_hit_next = free_hit_reg;
        free_idx_next = free_idx_reg;
        if (cmd.load_in)
        begin
            dst_hit_next  = 1'b0;
            src_hit_next  = 1'b0;
            ra_hit_next   = 1'b0;
            free_hit_next = 1'b0;
        end
        else if (pend_reg)
        begin
            if (ent_valid && ent_addr == dest_reg && !dst_hit_reg)
            begin
                dst_hit_next  = 1'b1;
                dst_port_next = ent_port;
            end
            if (ent_valid && ent_addr == src_reg && !src_hit_reg)
            begin
                src_hit_next  = 1'b1;
                src_port_next = ent_port;
            end
            if (ent_valid && ent_addr == raddr_reg && !ra_hit_reg)
            begin
                ra_hit_next = 1'b1;
                ra_idx_next = pend_idx_reg;
            end
            if (!ent_valid && !free_hit_reg)
            begin
                free_hit_next = 1'b1;
                free_idx_next = pend_idx_reg;
            end
        end
    end

    always_comb
    begin
        flood_n = active_ports;
        if (active_ports > bmt_pkg::ACTP_W'(bmt_pkg::NUM_PORTS))
        begin
            flood_n = bmt_pkg::ACTP_W'(bmt_pkg::NUM_PORTS);
        end
        for (int p = 0; p < bmt_pkg::MASK_W; p++)
        begin
            flood_mask[p] = (bmt_pkg::ACTP_W'(p) < flood_n)
                            && (bmt_pkg::PORT_W'(p) != src_port_reg);
        end
    end

    always_comb
    begin
        if (tick_reg)
        begin
            action_next = bmt_pkg::ACT_TICK;
            mask_next   = '0;
        end
        else if (dst_hit_reg)
        begin
            action_next = bmt_pkg::ACT_UNICAST;
            mask_next   = bmt_pkg::MASK_W'(1) << dst_port_reg;
        end
        else if (src_hit_reg)
        begin
            action_next = bmt_pkg::ACT_FLOOD;
            mask_next   = flood_mask;
        end
        else if (isreg_reg)
        begin
            action_next = (ra_hit_reg || free_hit_reg) ? bmt_pkg::ACT_LEARNED
                                                       : bmt_pkg::ACT_FULL;
            mask_next   = '0;
        end
        else
        begin
            action_next = bmt_pkg::ACT_DROP;
            mask_next   = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            pend_reg      <= cmd.scan_rd;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= cnt_reg;
        if (cmd.load_in)
        begin
            tick_reg  <= req_type;
            dest_reg  <= dest_addr;
            src_reg   <= src_addr;
            port_reg  <= arrival_port;
            isreg_reg <= is_register;
            raddr_reg <= registered_addr;
        end
        dst_hit_reg  <= dst_hit_next;
        dst_port_reg <= dst_port_next;
        src_hit_reg  <= src_hit_next;
        src_port_reg <= src_port_next;
        ra_hit_reg   <= ra_hit_next;
        ra_idx_reg   <= ra_idx_next;
        free_hit_reg <= free_hit_next;
        free_idx_reg <= free_idx_next;
        if (cmd.finish)
        begin
            action_reg <= action_next;
            mask_reg   <= mask_next;
        end
    end

    assign status.cnt_last = (cnt_reg == IW'(TABLE_DEPTH - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign action        = action_reg;
    assign out_port_mask = mask_reg;

endmodule

`default_nettype wire

[rtl/bmt_ctrl.sv]
// controller of the bridge address table: clearing pass, scan, result hand-off
// depends on bmt_pkg
`default_nettype none

module bmt_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire bmt_pkg::ctrl_status_t status,
    output bmt_pkg::ctrl_cmd_t         cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.cnt_last)
                begin
                    cmd.clr_wr    = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in   = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last entry is compared in this cycle
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/bridge_mac_table_with_aging.sv]
// bridge mac address table with aging, with lookup, flooding, learning and tick aging
// input word on s_t*, one result word on m_t*; registers on an apb-style port
// after reset a clearing pass writes every table entry with s_tready low;
// configuration writes are taken during it
// each word (frame or tick) scans the whole table once through the ram read port; after
// the scan and a drain state the result is loaded when the output register is free,
// and the next word can be taken in the cycle after the result is loaded
// a tick ages every valid entry by one in the same scan, writing back behind the read
// the result sits in an output register; a stalled receiver holds it, the next word
// can still be accepted and scanned, and only its result load waits for m_tready
// depends on bmt_pkg, bmt_ctrl, bmt_dp, bmt_ram and the defines header
`default_nettype none

`include "bridge_mac_table_with_aging_defines.svh"

module bridge_mac_table_with_aging #(
    parameter int TABLE_DEPTH = bmt_pkg::TABLE_DEPTH_DEF,
    parameter int LIFE_WIDTH  = bmt_pkg::LIFE_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // dest_addr[47:0], src_addr[95:48], arrival_port[98:96], registered_addr[146:99]
    input  wire logic [151:0] s_tdata,
    // req_type[0], is_register[1]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_port_mask[7:0]
    output logic      [7:0]   m_tdata,
    // action[2:0]
    output logic      [2:0]   m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    bmt_pkg::ctrl_cmd_t    cmd;
    bmt_pkg::ctrl_status_t status;

    logic [bmt_pkg::TOUT_W-1:0] timeout_reg;
    logic [bmt_pkg::ACTP_W-1:0] active_reg;
    logic                       cfg_wr;
    logic                       unicast_out;
    logic                       tick_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= bmt_pkg::TIMEOUT_RESET;
            active_reg  <= bmt_pkg::ACTIVE_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == bmt_pkg::REG_TIMEOUT)
            begin
                timeout_reg <= pwdata[bmt_pkg::TOUT_W-1:0];
            end
            else
            begin
                active_reg <= pwdata[bmt_pkg::ACTP_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == bmt_pkg::REG_ACTIVE) ? {28'd0, active_reg}
                                                      : {16'd0, timeout_reg};

    bmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bmt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .LIFE_WIDTH  (LIFE_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .req_type        (s_tuser[0]),
        .dest_addr       (s_tdata[47:0]),
        .src_addr        (s_tdata[95:48]),
        .arrival_port    (s_tdata[98:96]),
        .is_register     (s_tuser[1]),
        .registered_addr (s_tdata[146:99]),
        .entry_timeout   (timeout_reg),
        .active_ports    (active_reg),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .action          (m_tuser),
        .out_port_mask   (m_tdata)
    );

    assign unicast_out = m_tvalid && (m_tuser == bmt_pkg::ACT_UNICAST);
    assign tick_out    = m_tvalid && (m_tuser == bmt_pkg::ACT_TICK);

    // one word at a time: no second acceptance straight after one
    `BMT_ASSERT(a_one_at_a_time, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready)
    // a unicast goes to exactly one port
    `BMT_ASSERT(a_unicast_onehot, clk, rst_n, unicast_out |-> $onehot(m_tdata))
    // a tick result carries no ports
    `BMT_ASSERT(a_tick_no_mask, clk, rst_n, tick_out |-> (m_tdata == 8'd0))
    // nothing is offered or taken while in reset
    `BMT_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> (!m_tvalid && !s_tready))

endmodule

`default_nettype wire
